@@ src/rhsd_pkg.sv @@
package rhsd_pkg;

  localparam int HEADER_BYTES = 10;
  localparam int CELLS        = HEADER_BYTES - 1;
  localparam int SUM_BYTES    = HEADER_BYTES - 2;

  localparam logic [7:0] MARK_BYTE = 8'h14;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [7:0] INV_MASK  = 8'hFF;

  localparam logic EV_PAYLOAD = 1'b0;
  localparam logic EV_HEADER  = 1'b1;

  // header byte positions, 0 is the mark
  localparam int POS_ADDR3 = 1;
  localparam int POS_ADDR2 = 2;
  localparam int POS_ADDR1 = 3;
  localparam int POS_ADDR0 = 4;
  localparam int POS_ZERO  = 6;
  localparam int POS_LEN1  = 7;
  localparam int POS_LEN0  = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       mark;
  } cell_t;

  typedef struct packed {
    logic        event_kind;
    logic [31:0] target_address;
    logic [7:0]  payload_byte;
    logic [15:0] record_length;
    logic        last_in_record;
  } result_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] offset;
    logic [15:0] length;
  } hdr_t;

endpackage

@@ src/rhsd_if.sv @@
interface rhsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface rhsd_out_if;
  logic        valid;
  logic        ready;
  logic        event_kind;
  logic [31:0] target_address;
  logic [7:0]  payload_byte;
  logic [15:0] record_length;
  logic        last_in_record;

  modport source (output valid, output event_kind, output target_address,
                  output payload_byte, output record_length, output last_in_record,
                  input ready);
  modport sink   (input valid, input event_kind, input target_address,
                  input payload_byte, input record_length, input last_in_record,
                  output ready);
endinterface

@@ src/record_header_sync_deframer_top.sv @@
// Record header deframer. One stream byte is taken per clock while the
// two-entry result buffer has room, so the block runs at one byte per cycle
// and results appear in the cycle after transfer. While hunting, bytes move
// through a nine-cell shift chain; each 0x14 entering it is a header
// candidate, checked against the incoming byte when it reaches the last
// cell. A bad candidate is dropped and the next 0x14 already in the chain
// takes its turn. An accepted header gives a header event and the following
// record_length bytes pass through as payload events with running addresses.
module record_header_sync_deframer_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  rhsd_in_if.sink      in_i,
  rhsd_out_if.source   out_o
);

  rhsd_pkg::cell_t [rhsd_pkg::CELLS-1:0] cells;
  rhsd_pkg::cell_t [rhsd_pkg::CELLS-1:0] cells_in;
  rhsd_pkg::hdr_t                        hdr;
  rhsd_pkg::result_t                     res;
  rhsd_pkg::result_t                     res_out;

  logic        in_payload_q, in_payload_d;
  logic [15:0] remaining_q, remaining_d;
  logic [31:0] addr_q, addr_d;
  logic        buf_full;
  logic        fire;
  logic        hunt_shift;
  logic        hdr_accept;
  logic        push;
  logic [15:0] remaining_dec;

  assign in_i.ready = !buf_full;
  assign fire       = in_i.valid && !buf_full;
  assign hunt_shift = fire && !in_payload_q;
  assign hdr_accept = hunt_shift && hdr.ok;
  assign push       = fire && (in_payload_q || hdr_accept);

  always_comb begin
    cells_in[0].data = in_i.stream_byte;
    cells_in[0].mark = (in_i.stream_byte == rhsd_pkg::MARK_BYTE);
    for (int k = 1; k < rhsd_pkg::CELLS; k++) begin
      cells_in[k] = cells[k-1];
    end
  end

  for (genvar g = 0; g < rhsd_pkg::CELLS; g++) begin : g_cell
    rhsd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (hunt_shift),
      .clear_i (hdr_accept),
      .cell_i  (cells_in[g]),
      .cell_o  (cells[g])
    );
  end

  rhsd_check u_check (
    .cells_i (cells),
    .byte_i  (in_i.stream_byte),
    .hdr_o   (hdr)
  );

  assign remaining_dec = remaining_q - 16'd1;

  always_comb begin
    in_payload_d = in_payload_q;
    remaining_d  = remaining_q;
    addr_d       = addr_q;
    if (in_payload_q) begin
      res.event_kind     = rhsd_pkg::EV_PAYLOAD;
      res.target_address = addr_q;
      res.payload_byte   = in_i.stream_byte;
      res.record_length  = '0;
      res.last_in_record = (remaining_q == 16'd1);
      if (fire) begin
        addr_d       = addr_q + 32'd1;
        remaining_d  = remaining_dec;
        in_payload_d = (remaining_dec != 16'd0);
      end
    end else begin
      res.event_kind     = rhsd_pkg::EV_HEADER;
      res.target_address = hdr.offset;
      res.payload_byte   = '0;
      res.record_length  = hdr.length;
      res.last_in_record = 1'b0;
      if (hdr_accept) begin
        addr_d       = hdr.offset;
        remaining_d  = hdr.length;
        in_payload_d = (hdr.length != 16'd0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      remaining_q  <= '0;
      addr_q       <= '0;
    end else begin
      in_payload_q <= in_payload_d;
      remaining_q  <= remaining_d;
      addr_q       <= addr_d;
    end
  end

  rhsd_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .full_o  (buf_full),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (res_out)
  );

  assign out_o.event_kind     = res_out.event_kind;
  assign out_o.target_address = res_out.target_address;
  assign out_o.payload_byte   = res_out.payload_byte;
  assign out_o.record_length  = res_out.record_length;
  assign out_o.last_in_record = res_out.last_in_record;

endmodule

@@ src/rhsd_cell.sv @@
module rhsd_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  logic           clear_i,
  input  rhsd_pkg::cell_t cell_i,
  output rhsd_pkg::cell_t cell_o
);

  logic [7:0] data_q;
  logic       mark_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= 1'b0;
    end else if (clear_i) begin
      mark_q <= 1'b0;
    end else if (shift_i) begin
      mark_q <= cell_i.mark;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= cell_i.data;
    end
  end

  assign cell_o.data = data_q;
  assign cell_o.mark = mark_q;

endmodule

@@ src/rhsd_check.sv @@
module rhsd_check (
  input  rhsd_pkg::cell_t [rhsd_pkg::CELLS-1:0] cells_i,
  input  logic [7:0]                            byte_i,
  output rhsd_pkg::hdr_t                        hdr_o
);

  logic [7:0] win [rhsd_pkg::HEADER_BYTES];
  logic [7:0] sum;

  // oldest cell holds the first window byte
  always_comb begin
    for (int j = 0; j < rhsd_pkg::CELLS; j++) begin
      win[j] = cells_i[rhsd_pkg::CELLS-1-j].data;
    end
    win[rhsd_pkg::HEADER_BYTES-1] = byte_i;
  end

  always_comb begin
    sum = '0;
    for (int k = 1; k <= rhsd_pkg::SUM_BYTES; k++) begin
      sum = sum + win[k];
    end
  end

  assign hdr_o.ok = cells_i[rhsd_pkg::CELLS-1].mark
                 && (win[0] == rhsd_pkg::MARK_BYTE)
                 && (win[rhsd_pkg::POS_ZERO] == rhsd_pkg::ZERO_BYTE)
                 && ((sum ^ rhsd_pkg::INV_MASK) == win[rhsd_pkg::HEADER_BYTES-1]);
  assign hdr_o.offset = {win[rhsd_pkg::POS_ADDR3], win[rhsd_pkg::POS_ADDR2],
                         win[rhsd_pkg::POS_ADDR1], win[rhsd_pkg::POS_ADDR0]};
  assign hdr_o.length = {win[rhsd_pkg::POS_LEN1], win[rhsd_pkg::POS_LEN0]};

endmodule

@@ src/rhsd_obuf.sv @@
module rhsd_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rhsd_pkg::result_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              ready_i,
  output rhsd_pkg::result_t data_o
);

  rhsd_pkg::result_t mem_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;
  logic              pop;
  logic              push;

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign push    = push_i && !full_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ src/rhsd_sva.sv @@
module rhsd_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        event_kind_i,
  input logic [7:0]  payload_byte_i,
  input logic [15:0] record_length_i,
  input logic        last_in_record_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // input only stalls when results are waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no pending result");

  a_header_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == rhsd_pkg::EV_HEADER)
      |-> (payload_byte_i == 8'd0) && !last_in_record_i)
    else $error("header event carries payload fields");

  a_payload_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == rhsd_pkg::EV_PAYLOAD) |-> (record_length_i == 16'd0))
    else $error("payload event carries a length");

endmodule

bind record_header_sync_deframer_top rhsd_sva u_rhsd_sva (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .event_kind_i     (out_o.event_kind),
  .payload_byte_i   (out_o.payload_byte),
  .record_length_i  (out_o.record_length),
  .last_in_record_i (out_o.last_in_record)
);

@@ tb/sv/rhsd_checker.sv @@
module rhsd_checker
  import rhsd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  rhsd_in_if   in_if,
  rhsd_out_if  out_if,
  output int   errors_o,
  output int   pending_o,
  output int   headers_o,
  output int   payloads_o
);

  logic [7:0]  win [HEADER_BYTES];
  int          fill;
  logic        in_record;
  logic [15:0] bytes_left;
  logic [31:0] next_addr;
  result_t     expected_events [$];

  task automatic report(input string msg);
    if (errors_o < 30) $display("checker: %s", msg);
    errors_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report($sformatf("%s mismatch: got 0x%0h, want 0x%0h", name, got, want));
  endtask

  function automatic void shift_out_first();
    int k;
    if (fill == 0) return;
    for (k = 0; k < fill - 1; k++) win[k] = win[k + 1];
    fill--;
  endfunction

  function automatic void skip_to_mark();
    while (fill > 0 && win[0] != MARK_BYTE) shift_out_first();
  endfunction

  function automatic logic header_valid();
    logic [7:0] sum;
    int k;
    sum = ZERO_BYTE;
    if (win[0] != MARK_BYTE || win[POS_ZERO] != ZERO_BYTE) return 1'b0;
    for (k = 1; k <= SUM_BYTES; k++) sum = sum + win[k];
    return (sum ^ INV_MASK) == win[HEADER_BYTES - 1];
  endfunction

  // one stream byte in, zero or one expected event out
  function automatic void deframe_byte(input logic [7:0] b);
    result_t ev;
    if (in_record) begin
      ev.event_kind     = EV_PAYLOAD;
      ev.target_address = next_addr;
      ev.payload_byte   = b;
      ev.record_length  = 16'h0;
      ev.last_in_record = (bytes_left == 16'd1);
      expected_events.push_back(ev);
      next_addr  = next_addr + 32'd1;
      bytes_left = bytes_left - 16'd1;
      if (bytes_left == 16'd0) in_record = 1'b0;
      return;
    end
    if (fill >= HEADER_BYTES) fill = 0;
    win[fill] = b;
    fill++;
    skip_to_mark();
    if (fill < HEADER_BYTES) return;
    if (!header_valid()) begin
      shift_out_first();
      skip_to_mark();
      return;
    end
    ev.event_kind     = EV_HEADER;
    ev.target_address = {win[POS_ADDR3], win[POS_ADDR2], win[POS_ADDR1], win[POS_ADDR0]};
    ev.payload_byte   = ZERO_BYTE;
    ev.record_length  = {win[POS_LEN1], win[POS_LEN0]};
    ev.last_in_record = 1'b0;
    expected_events.push_back(ev);
    fill       = 0;
    next_addr  = ev.target_address;
    bytes_left = ev.record_length;
    in_record  = (ev.record_length != 16'h0);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t seen;
    result_t want;
    if (!rst_ni) begin
      fill       = 0;
      in_record  = 1'b0;
      bytes_left = 16'h0;
      next_addr  = 32'h0;
      expected_events.delete();
      errors_o   = 0;
      pending_o  = 0;
      headers_o  = 0;
      payloads_o = 0;
    end else begin
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) deframe_byte(in_if.stream_byte);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        seen.event_kind     = out_if.event_kind;
        seen.target_address = out_if.target_address;
        seen.payload_byte   = out_if.payload_byte;
        seen.record_length  = out_if.record_length;
        seen.last_in_record = out_if.last_in_record;
        if (expected_events.size() == 0) begin
          report($sformatf("unexpected transfer, kind %0b address 0x%08h",
                           seen.event_kind, seen.target_address));
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", 32'(seen.event_kind), 32'(want.event_kind));
          check_field("target_address", seen.target_address, want.target_address);
          check_field("payload_byte", 32'(seen.payload_byte), 32'(want.payload_byte));
          check_field("record_length", 32'(seen.record_length), 32'(want.record_length));
          check_field("last_in_record", 32'(seen.last_in_record),
                      32'(want.last_in_record));
          if (want.event_kind == EV_HEADER) headers_o++;
          else payloads_o++;
        end
      end
      pending_o = expected_events.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
module tb;
  import rhsd_pkg::*;

  typedef enum int {HDR_GOOD, HDR_BAD_SUM, HDR_BAD_ZERO, HDR_CUT} hdr_fault_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_EVERY4, RX_SPARSE} rx_mode_e;

  logic clk_i;
  logic rst_ni;

  rhsd_in_if  in_if ();
  rhsd_out_if out_if ();

  int errors;
  int pending;
  int headers_checked;
  int payloads_checked;
  int bytes_sent;
  int burst_left;
  int rx_cycle;
  rx_mode_e rx_mode;

  record_header_sync_deframer_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  rhsd_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .errors_o   (errors),
    .pending_o  (pending),
    .headers_o  (headers_checked),
    .payloads_o (payloads_checked)
  );

  always #6 clk_i = ~clk_i;

  // receiver stall pattern, drawn at random from the rx_mode_e modes
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 200 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   out_if.ready <= 1'b1;
      RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
      RX_EVERY4: out_if.ready <= (rx_cycle % 4 != 0);
      default:   out_if.ready <= (rx_cycle % 8 == 0);
    endcase
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_if.valid       <= 1'b1;
    in_if.stream_byte <= b;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    @(negedge clk_i);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_header(input logic [31:0] offset, input logic [15:0] len,
                             input hdr_fault_e fault);
    logic [7:0] h [HEADER_BYTES];
    logic [7:0] sum;
    int n;
    int k;
    h[0]             = MARK_BYTE;
    h[POS_ADDR3]     = offset[31:24];
    h[POS_ADDR2]     = offset[23:16];
    h[POS_ADDR1]     = offset[15:8];
    h[POS_ADDR0]     = offset[7:0];
    h[POS_ADDR0 + 1] = 8'($urandom_range(0, 255));
    h[POS_ZERO]      = (fault == HDR_BAD_ZERO) ? 8'($urandom_range(1, 255)) : ZERO_BYTE;
    h[POS_LEN1]      = len[15:8];
    h[POS_LEN0]      = len[7:0];
    sum = ZERO_BYTE;
    for (k = 1; k <= SUM_BYTES; k++) sum = sum + h[k];
    h[HEADER_BYTES - 1] = sum ^ INV_MASK;
    if (fault == HDR_BAD_SUM)
      h[HEADER_BYTES - 1] = h[HEADER_BYTES - 1] ^ 8'($urandom_range(1, 255));
    n = (fault == HDR_CUT) ? $urandom_range(1, HEADER_BYTES - 1) : HEADER_BYTES;
    for (k = 0; k < n; k++) send_byte(h[k]);
  endtask

  task automatic send_record(input logic [31:0] offset, input logic [15:0] len);
    int k;
    send_header(offset, len, HDR_GOOD);
    for (k = 0; k < len; k++)
      send_byte(($urandom_range(0, 7) == 0) ? MARK_BYTE : 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [15:0] pick_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 16'($urandom_range(0, 6));
    if (roll < 95) return 16'($urandom_range(7, 40));
    return 16'($urandom_range(41, 300));
  endfunction

  function automatic logic [31:0] pick_offset();
    if ($urandom_range(0, 9) == 0) return {24'hFF_FFFF, 8'($urandom_range(0, 255))};
    return $urandom;
  endfunction

  initial begin
    int roll;
    int n;
    int k;
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.stream_byte = 8'h00;
    out_if.ready      = 1'b0;
    bytes_sent        = 0;
    burst_left        = 0;
    rx_cycle          = 0;
    rx_mode           = RX_OPEN;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // stray byte, wrapping record with mark in payload, rejected window then zero length
    send_byte(8'hFF);
    send_header(32'hFFFF_FFFF, 16'd2, HDR_GOOD);
    send_byte(MARK_BYTE);
    send_byte(8'hFF);
    send_byte(MARK_BYTE);
    send_header(32'h0000_0000, 16'h0000, HDR_GOOD);

    while (bytes_sent < 1600) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        send_record(pick_offset(), pick_length());
      end else if (roll < 65) begin
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++)
          send_byte($urandom_range(0, 1) ? MARK_BYTE : 8'($urandom_range(0, 255)));
      end else if (roll < 75) begin
        send_header(pick_offset(), pick_length(), HDR_BAD_SUM);
      end else if (roll < 80) begin
        send_header(pick_offset(), pick_length(), HDR_BAD_ZERO);
      end else if (roll < 90) begin
        send_header(pick_offset(), pick_length(), HDR_CUT);
        send_record(pick_offset(), pick_length());
      end else begin
        // real header starting inside a rejected window
        send_byte(MARK_BYTE);
        n = $urandom_range(0, 8);
        for (k = 0; k < n; k++) send_byte(8'($urandom_range(0, 255)));
        send_record(pick_offset(), pick_length());
      end
    end

    // long record, wrapping the address
    for (k = 0; k < 20; k++) send_byte(ZERO_BYTE);
    send_record(32'hFFFF_FF80, 16'd160);

    in_if.valid <= 1'b0;
    for (k = 0; k < 10000 && pending != 0; k++) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("run: %0d stream bytes sent, %0d headers and %0d payload bytes checked",
             bytes_sent, headers_checked, payloads_checked);
    $display("run: %0d mismatches, %0d events never arrived", errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("tb: errors");
    $finish;
  end

endmodule
